// ===== rtl/core/sfd_pkg.sv =====
// Shared types and constants for the sensor frame deframer.
// Used by the top level and the port checker.
// No dependencies.
package sfd_pkg;

  // Default number of sensor channels in one frame.
  localparam int unsigned SENSOR_COUNT_DEF = 6;

  // Byte that closes a frame.
  localparam logic [7:0] FEED_BYTE = 8'h0A;

  // Scaling divisor and its truncated 2^32 reciprocal, floor(2^32 / 1023).
  localparam int unsigned  DIVISOR   = 1023;
  localparam logic [22:0]  RECIP     = 23'd4198404;

  // Result field widths and the packed stream widths.
  localparam int unsigned INDEX_W    = 3;
  localparam int unsigned RAW_W      = 16;
  localparam int unsigned SCALED_W   = 23;
  localparam int unsigned IN_TDATA_W = 8;
  localparam int unsigned OUT_TDATA_W = 48;

  // Control states of the deframer.
  typedef enum logic [2:0] {
    ST_RECV,
    ST_READ,
    ST_MUL,
    ST_FIX,
    ST_OUT
  } state_e;

endpackage

// ===== rtl/core/sfd_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// Used for the frame byte-pair store; depends on nothing else.
module sfd_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 6,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/sensor_frame_deframer.sv =====
// Sensor frame deframer top level: frames a serial byte stream at line feeds
// and emits one scaled reading per sensor. Depends on sfd_pkg and sfd_ram.
//
//   Channel   Group     Payload (lowest bit first)
//   -------   -------   ---------------------------------------------------
//   input     s_axis    tdata: rx_byte[7:0]
//   output    m_axis    tdata: sensor_index[2:0], raw_reading[18:3],
//                              scaled_reading[41:19], zero[47:42]
//                       tlast: last_of_frame
//
// Bytes are taken only while the block is receiving. A line feed that closes
// a frame of the right length starts a burst of SENSOR_COUNT results; each
// result takes four steps (RAM read, multiply by the reciprocal, remainder
// correction, output, which waits for the transaction), and no input is
// taken during the burst. Reset clears the byte counter and the control
// state; the frame RAM is not cleared. Output stalls hold the result.
module sensor_frame_deframer #(
  parameter int unsigned SENSOR_COUNT = sfd_pkg::SENSOR_COUNT_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  // Input stream: rx_byte[7:0].
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [sfd_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // Output stream: sensor_index[2:0], raw_reading[18:3],
  // scaled_reading[41:19], zero fill[47:42].
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [sfd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // last_of_frame.
  output logic                               m_axis_tlast
);

  localparam int unsigned DATA_LEN  = 2 * SENSOR_COUNT;
  localparam int unsigned FRAME_LEN = DATA_LEN + 1;
  localparam int unsigned COUNT_MAX = DATA_LEN + 2;
  localparam int unsigned CNT_W     = $clog2(COUNT_MAX + 1);
  localparam int unsigned IDX_W     = (SENSOR_COUNT > 1) ? $clog2(SENSOR_COUNT) : 1;
  localparam int unsigned RAW_W     = sfd_pkg::RAW_W;
  localparam int unsigned SCALED_W  = sfd_pkg::SCALED_W;
  localparam int unsigned PROD_W    = RAW_W + SCALED_W;
  localparam int unsigned NUM_W     = RAW_W + 16;

  localparam logic [CNT_W-1:0] DataLenC  = CNT_W'(DATA_LEN);
  localparam logic [CNT_W-1:0] FrameLenC = CNT_W'(FRAME_LEN);
  localparam logic [CNT_W-1:0] CountMaxC = CNT_W'(COUNT_MAX);
  localparam logic [IDX_W-1:0] LastIdxC  = IDX_W'(SENSOR_COUNT - 1);
  localparam logic [NUM_W:0]   DivisorC  = (NUM_W + 1)'(sfd_pkg::DIVISOR);

  sfd_pkg::state_e state_q, state_d;

  logic [CNT_W-1:0]    cnt_q, cnt_d;
  logic [IDX_W-1:0]    sidx_q, sidx_d;
  logic [7:0]          hi_q;
  logic [RAW_W-1:0]    raw_q;
  logic [PROD_W-1:0]   prod_q;
  logic [RAW_W-1:0]    out_raw_q;
  logic [SCALED_W-1:0] out_scaled_q;
  logic [IDX_W-1:0]    out_idx_q;
  logic                out_last_q;

  logic                in_xact;
  logic                out_xact;
  logic                is_feed;
  logic                ram_we;
  logic                ram_re;
  logic [IDX_W-1:0]    ram_waddr;
  logic [RAW_W-1:0]    ram_rdata;

  logic [SCALED_W-1:0] q_est;
  logic [NUM_W:0]      num_ext;
  logic [NUM_W:0]      back_prod;
  logic [NUM_W:0]      remainder;
  logic [SCALED_W-1:0] q_fix;

  assign in_xact  = s_axis_tvalid && s_axis_tready;
  assign out_xact = m_axis_tvalid && m_axis_tready;
  assign is_feed  = (s_axis_tdata == sfd_pkg::FEED_BYTE);

  // A data byte at an odd position completes a byte pair, written as one word.
  assign ram_waddr = IDX_W'(cnt_q >> 1);
  assign ram_we    = in_xact && !is_feed && (cnt_q < DataLenC) && cnt_q[0];
  assign ram_re    = (state_q == sfd_pkg::ST_READ);

  sfd_ram #(
    .WIDTH (RAW_W),
    .DEPTH (SENSOR_COUNT)
  ) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({hi_q, s_axis_tdata}),
    .re_i    (ram_re),
    .raddr_i (sidx_q),
    .rdata_o (ram_rdata)
  );

  // Next state, byte counter and sensor index.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    sidx_d  = sidx_q;
    case (state_q)
      sfd_pkg::ST_RECV: begin
        if (in_xact) begin
          if (is_feed) begin
            cnt_d  = '0;
            sidx_d = '0;
            if (cnt_q == FrameLenC) begin
              state_d = sfd_pkg::ST_READ;
            end
          end else if (cnt_q < CountMaxC) begin
            cnt_d = cnt_q + 1'b1;
          end
        end
      end
      sfd_pkg::ST_READ: state_d = sfd_pkg::ST_MUL;
      sfd_pkg::ST_MUL:  state_d = sfd_pkg::ST_FIX;
      sfd_pkg::ST_FIX:  state_d = sfd_pkg::ST_OUT;
      sfd_pkg::ST_OUT: begin
        if (out_xact) begin
          if (sidx_q == LastIdxC) begin
            state_d = sfd_pkg::ST_RECV;
          end else begin
            sidx_d  = sidx_q + 1'b1;
            state_d = sfd_pkg::ST_READ;
          end
        end
      end
      default: state_d = sfd_pkg::ST_RECV;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sfd_pkg::ST_RECV;
      cnt_q   <= '0;
      sidx_q  <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      sidx_q  <= sidx_d;
    end
  end

  // Reciprocal estimate is low by at most one; the remainder fixes it.
  assign q_est     = prod_q[PROD_W-1:16];
  assign num_ext   = {1'b0, raw_q, 16'b0};
  assign back_prod = {q_est, 10'b0} - (NUM_W + 1)'(q_est);
  assign remainder = num_ext - back_prod;
  assign q_fix     = q_est + SCALED_W'(remainder >= DivisorC);

  // Datapath registers: high byte holding, multiply stage and output stage.
  always_ff @(posedge clk_i) begin
    if (in_xact && !is_feed && !cnt_q[0]) begin
      hi_q <= s_axis_tdata;
    end
    if (state_q == sfd_pkg::ST_MUL) begin
      raw_q  <= ram_rdata;
      prod_q <= PROD_W'(ram_rdata) * PROD_W'(sfd_pkg::RECIP);
    end
    if (state_q == sfd_pkg::ST_FIX) begin
      out_raw_q    <= raw_q;
      out_scaled_q <= q_fix;
      out_idx_q    <= sidx_q;
      out_last_q   <= (sidx_q == LastIdxC);
    end
  end

  assign s_axis_tready = (state_q == sfd_pkg::ST_RECV);
  assign m_axis_tvalid = (state_q == sfd_pkg::ST_OUT);
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {6'b0, out_scaled_q, out_raw_q, sfd_pkg::INDEX_W'(out_idx_q)};

endmodule

// ===== rtl/core/sfd_checker.sv =====
// Port-level checker for the sensor frame deframer, bound to the top level.
// Depends on sfd_pkg; sees only the top-level ports.
module sfd_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic [sfd_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [sfd_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                            m_axis_tlast
);

  logic [40:0] num_w;
  logic [40:0] back_w;

  // Scaled field times the divisor must sit within one divisor of raw * 2^16.
  assign num_w  = {9'b0, m_axis_tdata[18:3], 16'b0};
  assign back_w = 41'(m_axis_tdata[41:19]) * 41'(sfd_pkg::DIVISOR);

  // A stalled result transaction keeps its payload.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output payload changed while stalled");

  // Input is never taken while a result is on offer.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input ready during result burst");

  // After the last result of a frame the block goes back to receiving.
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid)
    else $error("result offered after last of frame");

  // The scaled reading is the truncated quotient of raw * 2^16 by the divisor.
  a_scaled_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (back_w <= num_w) &&
      ((num_w - back_w) < 41'(sfd_pkg::DIVISOR)))
    else $error("scaled reading does not match raw reading");

  // A line feed with no data ahead of it never starts a burst.
  a_empty_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && (s_axis_tdata == sfd_pkg::FEED_BYTE) ##1
      s_axis_tvalid && s_axis_tready && (s_axis_tdata == sfd_pkg::FEED_BYTE)
      |=> s_axis_tready)
    else $error("empty frame produced results");

endmodule

bind sensor_frame_deframer sfd_checker u_sfd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
